[hdl/gpr_pkg.sv]
// shared constants for the 5-tap binomial blur / pyramid reduce block
// register codes, field widths, reset values and default parameters
// no dependencies
`default_nettype none

package gpr_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_PIXEL_BITS = 16;

    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 16;
    localparam int CFG_ADDR_W     = 2;
    localparam int CFG_DATA_W     = 16;

    localparam logic [FRAME_WIDTH_W-1:0]  RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [FRAME_HEIGHT_W-1:0] RST_FRAME_HEIGHT = 16'd768;
    localparam logic                      RST_MODE         = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_MODE         = 2'd2
    } cfg_index_t;

endpackage

`default_nettype wire

[hdl/gaussian_pyramid_reduce.sv]
// top level of the 5-tap binomial blur / gaussian pyramid reduce
// line memory with read-modify-write, vertical sums, column windows, result sequencer
// depends on gpr_pkg
//
//  channel   direction  handshake              payload
//  cfg       in         cfg_valid/cfg_ready    cfg_addr index, cfg_data value
//  s_        in         s_tvalid/s_tready      s_tdata pixel_in
//  m_        out        m_tvalid/m_tready      m_tdata pixel_out, m_tlast end_of_frame,
//                                              m_tuser end_of_row, last_in_run
//
// one pixel per clock while each pixel gives at most one result and m_tready is high;
// a pixel with more results holds the input, as the horizontal sum and output path is single
// a result passes the line memory read, column window and output registers in turn
// no clearing pass after reset; the line memory word is only used where the frame has written
// m_tready low stalls the sequencer, then the memory stage, then s_tready
`default_nettype none

module gaussian_pyramid_reduce #(
    parameter int MAX_WIDTH  = gpr_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = gpr_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [gpr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [gpr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // pixel_in
    input  wire logic [((PIXEL_BITS+7)/8)*8-1:0]     s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // pixel_out
    output logic [((PIXEL_BITS+7)/8)*8-1:0]          m_tdata,
    output logic                                     m_tlast,
    // end_of_row, last_in_run
    output logic [1:0]                               m_tuser
);

    localparam int DATA_W = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int CW     = WW + 1;
    localparam int RW     = gpr_pkg::FRAME_HEIGHT_W;
    localparam int RRW    = RW + 1;
    localparam int SUM_W  = PIXEL_BITS + 4;
    localparam int HS_W   = PIXEL_BITS + 8;
    localparam int WORD_W = 4 * PIXEL_BITS;

    // configuration
    logic [gpr_pkg::FRAME_WIDTH_W-1:0]  frame_width_reg;
    logic [gpr_pkg::FRAME_HEIGHT_W-1:0] frame_height_reg;
    logic                               mode_reg;
    logic                               cfg_known;
    logic                               cfg_restart;

    logic [WW-1:0] width_eff;
    logic [RW-1:0] height_eff;
    logic [WW-1:0] out_w;
    logic [WW-1:0] last_oc;
    logic [RW-1:0] out_h;
    logic [RW-1:0] last_or;

    // input stage
    logic [XW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic          in_accept;
    logic          last_col_s0;
    logic          last_row_s0;

    // line memory, four earlier rows per column, newest in the low slot
    logic [WORD_W-1:0] line_mem [MAX_WIDTH];
    logic [WORD_W-1:0] rd_word_reg;
    logic [WORD_W-1:0] wr_word;
    logic              fwd_hit_reg;
    logic [WORD_W-1:0] fwd_word_reg;

    // memory stage
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [XW-1:0]         s1_x_reg;
    logic [RW-1:0]         s1_y_reg;
    logic                  s1_last_col_reg;
    logic                  s1_last_row_reg;
    logic                  s1_fire;

    logic [WORD_W-1:0]     word;
    logic [PIXEL_BITS-1:0] tp [5];
    logic [SUM_W-1:0]      vs [3];
    logic [2:0]            act;
    logic [2:0]            col_ok;
    logic [2:0]            col_last;
    logic [2:0]            row_ok;
    logic [2:0]            row_last;
    logic [8:0]            mask_s1;

    logic [SUM_W-1:0] win_reg [3][5];

    // result sequencer
    logic [8:0]       e_mask_reg;
    logic [8:0]       e_mask_next;
    logic [2:0]       e_col_last_reg;
    logic [2:0]       e_row_last_reg;
    logic             e_step;
    logic             e_free;
    logic             out_free;
    logic [1:0]       sel_ph;
    logic [1:0]       sel_k;
    logic [3:0]       sel_idx;
    logic [8:0]       mask_rest;
    logic [SUM_W-1:0] wsel [5];
    logic [SUM_W-1:0] ht [5];
    logic [HS_W-1:0]  hsum;

    // output register
    logic              m_tvalid_reg;
    logic [DATA_W-1:0] m_tdata_reg;
    logic              m_tlast_reg;
    logic [1:0]        m_tuser_reg;

    assign cfg_ready = 1'b1;

    always_comb begin
        case (gpr_pkg::cfg_index_t'(cfg_addr))
            gpr_pkg::CFG_FRAME_WIDTH,
            gpr_pkg::CFG_FRAME_HEIGHT,
            gpr_pkg::CFG_MODE: cfg_known = 1'b1;
            default:           cfg_known = 1'b0;
        endcase
    end

    assign cfg_restart = cfg_valid && cfg_ready && cfg_known;

    // effective frame geometry
    always_comb begin
        if (frame_width_reg == '0) begin
            width_eff = WW'(1);
        end else if (int'(frame_width_reg) > MAX_WIDTH) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(frame_width_reg);
        end
        height_eff = (frame_height_reg == '0) ? RW'(1) : frame_height_reg;
        if (mode_reg) begin
            out_w   = {width_eff[WW-1:1], 1'b0};
            out_h   = {height_eff[RW-1:1], 1'b0};
            last_oc = (out_w >= WW'(2)) ? out_w - WW'(2) : '0;
            last_or = (out_h >= RW'(2)) ? out_h - RW'(2) : '0;
        end else begin
            out_w   = width_eff;
            out_h   = height_eff;
            last_oc = width_eff - WW'(1);
            last_or = height_eff - RW'(1);
        end
    end

    // handshakes
    assign out_free  = !m_tvalid_reg || m_tready;
    assign e_step    = (e_mask_reg != '0) && out_free;
    assign e_free    = (e_mask_reg == '0) || (e_step && (mask_rest == '0));
    assign s1_fire   = s1_valid_reg && e_free;
    assign s_tready  = !s1_valid_reg || s1_fire;
    assign in_accept = s_tvalid && s_tready;

    assign last_col_s0 = (WW'(col_reg) == width_eff - WW'(1));
    assign last_row_s0 = (row_reg == height_eff - RW'(1));

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (in_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end
    end

    // memory stage: taps, vertical sums, result mask
    always_comb begin
        word  = fwd_hit_reg ? fwd_word_reg : rd_word_reg;
        tp[0] = s1_pix_reg;
        for (int k = 1; k < 5; k++) begin
            tp[k] = (s1_y_reg >= RW'(k)) ? word[(k-1)*PIXEL_BITS +: PIXEL_BITS] : tp[k-1];
        end
        wr_word = {word[3*PIXEL_BITS-1:0], s1_pix_reg};

        vs[0] = SUM_W'(tp[4]) + (SUM_W'(tp[3]) << 2) + SUM_W'(tp[2]) * SUM_W'(6)
              + (SUM_W'(tp[1]) << 2) + SUM_W'(tp[0]);
        vs[1] = SUM_W'(tp[3]) + (SUM_W'(tp[2]) << 2) + SUM_W'(tp[1]) * SUM_W'(6)
              + SUM_W'(tp[0]) * SUM_W'(5);
        vs[2] = SUM_W'(tp[2]) + (SUM_W'(tp[1]) << 2) + SUM_W'(tp[0]) * SUM_W'(11);

        act[0] = (s1_y_reg >= RW'(2));
        act[1] = s1_last_row_reg && (s1_y_reg != '0);
        act[2] = s1_last_row_reg;
    end

    always_comb begin
        logic [CW-1:0]  cs;
        logic [CW-1:0]  c;
        logic [RRW-1:0] rr;
        for (int ph = 0; ph < 3; ph++) begin
            cs = CW'(s1_x_reg) + CW'(ph);
            c  = cs - CW'(2);
            col_ok[ph]   = ((ph == 0) || s1_last_col_reg) && (cs >= CW'(2))
                         && (c < CW'(out_w)) && (!mode_reg || !c[0]);
            col_last[ph] = (cs >= CW'(2)) && (c == CW'(last_oc));
        end
        for (int k = 0; k < 3; k++) begin
            rr = RRW'(s1_y_reg) + RRW'(k) - RRW'(2);
            row_ok[k]   = act[k] && (rr < RRW'(out_h)) && (!mode_reg || !rr[0]);
            row_last[k] = (rr == RRW'(last_or));
        end
        for (int ph = 0; ph < 3; ph++) begin
            for (int k = 0; k < 3; k++) begin
                mask_s1[ph*3+k] = col_ok[ph] && row_ok[k];
            end
        end
    end

    // sequencer: next result in column order, upper row first
    always_comb begin
        sel_ph  = '0;
        sel_k   = '0;
        sel_idx = '0;
        for (int ph = 2; ph >= 0; ph--) begin
            for (int k = 2; k >= 0; k--) begin
                if (e_mask_reg[ph*3+k]) begin
                    sel_ph  = 2'(ph);
                    sel_k   = 2'(k);
                    sel_idx = 4'(ph*3+k);
                end
            end
        end
        mask_rest = e_mask_reg & ~(9'b1 << sel_idx);

        e_mask_next = e_mask_reg;
        if (s1_fire) begin
            e_mask_next = mask_s1;
        end else if (e_step) begin
            e_mask_next = mask_rest;
        end
    end

    always_comb begin
        case (sel_k)
            2'd0: for (int j = 0; j < 5; j++) wsel[j] = win_reg[0][j];
            2'd1: for (int j = 0; j < 5; j++) wsel[j] = win_reg[1][j];
            2'd2: for (int j = 0; j < 5; j++) wsel[j] = win_reg[2][j];
            default: for (int j = 0; j < 5; j++) wsel[j] = win_reg[0][j];
        endcase
        // flushing columns past the right edge replicate the last sum
        case (sel_ph)
            2'd0: for (int j = 0; j < 5; j++) ht[j] = wsel[j];
            2'd1: for (int j = 0; j < 5; j++) ht[j] = wsel[(j + 1 > 4) ? 4 : j + 1];
            2'd2: for (int j = 0; j < 5; j++) ht[j] = wsel[(j + 2 > 4) ? 4 : j + 2];
            default: for (int j = 0; j < 5; j++) ht[j] = wsel[j];
        endcase
        hsum = HS_W'(ht[0]) + (HS_W'(ht[1]) << 2) + HS_W'(ht[2]) * HS_W'(6)
             + (HS_W'(ht[3]) << 2) + HS_W'(ht[4]) + HS_W'(128);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= gpr_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= gpr_pkg::RST_FRAME_HEIGHT;
            mode_reg         <= gpr_pkg::RST_MODE;
            col_reg          <= '0;
            row_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            e_mask_reg       <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (gpr_pkg::cfg_index_t'(cfg_addr))
                    gpr_pkg::CFG_FRAME_WIDTH:
                        frame_width_reg <= cfg_data[gpr_pkg::FRAME_WIDTH_W-1:0];
                    gpr_pkg::CFG_FRAME_HEIGHT:
                        frame_height_reg <= cfg_data[gpr_pkg::FRAME_HEIGHT_W-1:0];
                    gpr_pkg::CFG_MODE:
                        mode_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cfg_restart) begin
                col_reg <= '0;
                row_reg <= '0;
            end else if (in_accept) begin
                if (last_col_s0) begin
                    col_reg <= '0;
                    row_reg <= last_row_s0 ? '0 : row_reg + RW'(1);
                end else begin
                    col_reg <= col_reg + XW'(1);
                end
            end
            s1_valid_reg <= s1_valid_next;
            e_mask_reg   <= e_mask_next;
            if (e_step) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // line memory
    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            line_mem[s1_x_reg] <= wr_word;
        end
        if (in_accept) begin
            rd_word_reg <= line_mem[col_reg];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_pix_reg      <= s_tdata[PIXEL_BITS-1:0];
            s1_x_reg        <= col_reg;
            s1_y_reg        <= row_reg;
            s1_last_col_reg <= last_col_s0;
            s1_last_row_reg <= last_row_s0;
            // same column written back while it is read
            fwd_hit_reg     <= s1_fire && (s1_x_reg == col_reg);
            fwd_word_reg    <= wr_word;
        end
        if (s1_fire) begin
            e_col_last_reg <= col_last;
            e_row_last_reg <= row_last;
            for (int k = 0; k < 3; k++) begin
                if (act[k]) begin
                    if (s1_x_reg == '0) begin
                        for (int j = 0; j < 5; j++) win_reg[k][j] <= vs[k];
                    end else begin
                        for (int j = 0; j < 4; j++) win_reg[k][j] <= win_reg[k][j+1];
                        win_reg[k][4] <= vs[k];
                    end
                end
            end
        end
        if (e_step) begin
            m_tdata_reg    <= DATA_W'(hsum[HS_W-1:8]);
            m_tlast_reg    <= e_col_last_reg[sel_ph] && e_row_last_reg[sel_k];
            m_tuser_reg[0] <= e_col_last_reg[sel_ph];
            m_tuser_reg[1] <= (mask_rest == '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire
